// ===== design/n2i_pkg.sv =====
// Package for the numeral to integer parser: parse phases and character codes.
// Used by numeral_to_int64_parser_unit. Depends on nothing else.
package n2i_pkg;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_START,
        PH_ZERO,
        PH_HEX,
        PH_DEC,
        PH_TRAIL
    } phase_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int unsigned RADIX_DEC = 10;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== design/numeral_to_int64_parser_unit.sv =====
// Numeral to signed integer parser, top level.
// Depends on n2i_pkg for the phase type, character codes and class helpers.
//
// Usage: the slave stream carries one text byte per word in s_tdata; a word
// with s_tlast high is the terminator and its data byte is ignored. Leading
// whitespace, one optional sign, a "0x"/"0X" hex prefix, digits and trailing
// whitespace are recognized. Each terminator word yields exactly one result
// word on the master stream: m_tuser is the ok flag and m_tdata the value,
// sign-extended from INT_WIDTH bits to 64, zero when ok is low. Character
// words yield no result. Decimal numerals that exceed the signed range fail.
// Throughput is one word per cycle while no terminator is held back by a
// stalled result. A word is captured in an input register and handled by the
// parse step, which on a terminator loads the result register that sets
// m_tvalid and carries the value and ok flag. The result register holds
// one word; while it is stalled by m_tready, characters keep flowing and only
// a terminator waits in the input register, which then lowers s_tready until
// the result is taken. A synchronous low on aresetn empties both registers and
// returns the parser to the leading whitespace phase with no sign, no digits
// and no failure. Failure is sticky until the terminator, after which the
// parser starts a fresh numeral.
module numeral_to_int64_parser_unit #(
    parameter int INT_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic        m_tuser    // [0] ok
);

    localparam logic [INT_WIDTH-1:0] MAX_POS   = {1'b0, {(INT_WIDTH-1){1'b1}}};
    localparam logic [INT_WIDTH-1:0] MAX_BY10  = INT_WIDTH'(MAX_POS / n2i_pkg::RADIX_DEC);
    localparam logic [3:0]           LAST_DIG  = 4'(MAX_POS % n2i_pkg::RADIX_DEC);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       in_advance;
    logic       in_fire;

    // Parser state.
    n2i_pkg::phase_t       phase_reg, phase_next;
    logic [INT_WIDTH-1:0]  acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic                  no_dig_reg, no_dig_next;
    logic                  failed_reg, failed_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_value_reg, out_value_next;
    logic        out_ok_reg, out_ok_next;

    // Per-character helpers.
    logic [3:0]           dec_val;
    logic [3:0]           hex_val;
    logic                 hex_hit;
    logic [INT_WIDTH-1:0] dec_acc;
    logic [INT_WIDTH-1:0] hex_acc;
    logic                 dec_ovf;
    logic                 do_start;
    logic [INT_WIDTH-1:0] mag;
    logic                 ok_now;

    // A character never blocks; a terminator waits for room in the result register.
    assign in_advance = !in_last_reg || !out_valid_reg || m_tready;
    assign in_fire    = in_valid_reg && in_advance;
    assign s_tready   = !in_valid_reg || in_advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (in_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Digit values and the two accumulate candidates (shift-add, no multiplier).
    always_comb begin
        dec_val = 4'(in_char_reg - n2i_pkg::CH_ZERO);
        hex_hit = 1'b1;
        hex_val = dec_val;
        if (n2i_pkg::is_dec(in_char_reg)) begin
            hex_val = dec_val;
        end else if (in_char_reg >= n2i_pkg::CH_LOW_A && in_char_reg <= n2i_pkg::CH_LOW_F) begin
            hex_val = 4'(in_char_reg - n2i_pkg::CH_LOW_A + 8'd10);
        end else if (in_char_reg >= n2i_pkg::CH_UP_A && in_char_reg <= n2i_pkg::CH_UP_F) begin
            hex_val = 4'(in_char_reg - n2i_pkg::CH_UP_A + 8'd10);
        end else begin
            hex_hit = 1'b0;
        end
        dec_acc = (acc_reg << 3) + (acc_reg << 1) + INT_WIDTH'(dec_val);
        hex_acc = (acc_reg << 4) | INT_WIDTH'(hex_val);
        // The digit that would push the magnitude past the limit is refused.
        dec_ovf = (acc_reg > MAX_BY10) ||
                  ((acc_reg == MAX_BY10) && ({1'b0, dec_val} > ({1'b0, LAST_DIG} + 5'(neg_reg))));
    end

    // Parse step.
    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        no_dig_next = no_dig_reg;
        failed_next = failed_reg;
        do_start    = 1'b0;

        if (in_fire && in_last_reg) begin
            phase_next  = n2i_pkg::PH_LEAD;
            acc_next    = '0;
            neg_next    = 1'b0;
            no_dig_next = 1'b1;
            failed_next = 1'b0;
        end else if (in_fire && !failed_reg) begin
            unique case (phase_reg)
                n2i_pkg::PH_LEAD: begin
                    if (n2i_pkg::is_ws(in_char_reg)) begin
                        phase_next = n2i_pkg::PH_LEAD;
                    end else if (in_char_reg == n2i_pkg::CH_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = n2i_pkg::PH_START;
                    end else if (in_char_reg == n2i_pkg::CH_PLUS) begin
                        phase_next = n2i_pkg::PH_START;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                n2i_pkg::PH_START: begin
                    do_start = 1'b1;
                end
                n2i_pkg::PH_ZERO: begin
                    if (in_char_reg == n2i_pkg::CH_LOW_X || in_char_reg == n2i_pkg::CH_UP_X) begin
                        no_dig_next = 1'b1;
                        acc_next    = '0;
                        phase_next  = n2i_pkg::PH_HEX;
                    end else if (n2i_pkg::is_dec(in_char_reg)) begin
                        if (dec_ovf) begin
                            failed_next = 1'b1;
                        end else begin
                            acc_next    = dec_acc;
                            no_dig_next = 1'b0;
                            phase_next  = n2i_pkg::PH_DEC;
                        end
                    end else if (n2i_pkg::is_ws(in_char_reg)) begin
                        phase_next = n2i_pkg::PH_TRAIL;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                n2i_pkg::PH_HEX: begin
                    if (hex_hit) begin
                        acc_next    = hex_acc;
                        no_dig_next = 1'b0;
                    end else if (n2i_pkg::is_ws(in_char_reg)) begin
                        phase_next = n2i_pkg::PH_TRAIL;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                n2i_pkg::PH_DEC: begin
                    if (n2i_pkg::is_dec(in_char_reg)) begin
                        if (dec_ovf) begin
                            failed_next = 1'b1;
                        end else begin
                            acc_next    = dec_acc;
                            no_dig_next = 1'b0;
                        end
                    end else if (n2i_pkg::is_ws(in_char_reg)) begin
                        phase_next = n2i_pkg::PH_TRAIL;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                n2i_pkg::PH_TRAIL: begin
                    if (!n2i_pkg::is_ws(in_char_reg)) begin
                        failed_next = 1'b1;
                    end
                end
                default: begin
                    failed_next = 1'b1;
                end
            endcase

            // First character of the magnitude, with or without a sign before it.
            if (do_start) begin
                if (in_char_reg == n2i_pkg::CH_ZERO) begin
                    acc_next    = '0;
                    no_dig_next = 1'b0;
                    phase_next  = n2i_pkg::PH_ZERO;
                end else if (n2i_pkg::is_dec(in_char_reg)) begin
                    if (dec_ovf) begin
                        failed_next = 1'b1;
                    end else begin
                        acc_next    = dec_acc;
                        no_dig_next = 1'b0;
                        phase_next  = n2i_pkg::PH_DEC;
                    end
                end else begin
                    failed_next = 1'b1;
                end
            end
        end
    end

    // Result formation on the terminator.
    always_comb begin
        ok_now         = !failed_reg && !no_dig_reg;
        mag            = neg_reg ? (INT_WIDTH'(0) - acc_reg) : acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_ok_next    = out_ok_reg;
        out_value_next = out_value_reg;
        if (in_fire && in_last_reg) begin
            out_valid_next = 1'b1;
            out_ok_next    = ok_now;
            out_value_next = ok_now ? 64'($signed(mag)) : 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= n2i_pkg::PH_LEAD;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            no_dig_reg    <= 1'b1;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            no_dig_reg    <= no_dig_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
        out_ok_reg    <= out_ok_next;
        out_value_reg <= out_value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_ok_reg;

endmodule

// ===== design/n2i_checker.sv =====
// Port-level checks for numeral_to_int64_parser_unit, attached by bind.
// Sees only the top level's ports; no package dependency.
module n2i_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result word keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A failed numeral reports a zero value.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 64'd0)
        else $error("failed result carries a nonzero value");

    // A result appears from an empty output only after an accepted terminator has passed through the input register.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result word without a terminator");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind numeral_to_int64_parser_unit n2i_checker u_n2i_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
